>>> hw/rtl/vdis_pkg.sv
// Package for the voltage dip and interval statistics unit.
// Holds widths, register indexes, request and result structs, and the
// control structs shared by the top level, the shared ALU and the divider.
`default_nettype none

package vdis_pkg;

  // Sample and moving average format
  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned EMA_FRAC_BITS = 16;
  localparam int unsigned AVG_W         = SAMPLE_BITS + EMA_FRAC_BITS;

  // Field widths of the request and result items
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned STAMP_W  = 63;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned GAP_W    = 40;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned MARGIN_W = 13;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Shared ALU widths
  localparam int unsigned ALU_W    = 64;
  localparam int unsigned MULB_W   = WEIGHT_W + 1;
  localparam int unsigned PROD_W   = AVG_W + MULB_W;

  // Width for the signed compare of (scaled - avg) against margin << frac
  localparam int unsigned THR_W    = MARGIN_W + EMA_FRAC_BITS;
  localparam int unsigned CMP_W    = ((AVG_W > THR_W) ? AVG_W : THR_W) + 2;

  // Serial divider step counter
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_MARGIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT   = 2'd2;

  // Register reset values
  localparam logic [MARGIN_W-1:0] DIP_MARGIN_RST   = 13'd228;
  localparam logic [MARGIN_W-1:0] REARM_MARGIN_RST = 13'd296;
  localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST   = 16'd66;

  // Request type codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [LEVEL_W-1:0] sample_level;
    logic [STAMP_W-1:0] sample_time_ns;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [LEVEL_W-1:0] mean_level;
    logic [CNT_W-1:0]   dips_seen;
    logic [CNT_W-1:0]   samples_seen;
    logic [GAP_W-1:0]   min_gap_ns;
    logic [GAP_W-1:0]   max_gap_ns;
    logic [GAP_W-1:0]   mean_gap_ns;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MAC = 2'd2
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
    logic [MULB_W-1:0] m;
  } alu_req_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/vdis_alu.sv
// Shared arithmetic unit: one multiplier and one 64-bit adder.
// MAC computes a * m + b, ADD and SUB compute a +/- b with carry out.
// Depends on vdis_pkg.
`default_nettype none

module vdis_alu (
  input  vdis_pkg::alu_req_t      alu_req_i,
  output logic [vdis_pkg::ALU_W:0] alu_res_o
);
  import vdis_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [ALU_W-1:0]  add_x;
  logic [ALU_W-1:0]  add_y;
  logic              add_cin;

  // Multiply the low average-width bits of a by the 17-bit operand
  assign prod = PROD_W'(alu_req_i.a[AVG_W-1:0]) * PROD_W'(alu_req_i.m);

  // Select adder operands
  always_comb begin
    add_x   = alu_req_i.a;
    add_y   = alu_req_i.b;
    add_cin = 1'b0;
    unique case (alu_req_i.op)
      ALU_ADD: begin
        add_x = alu_req_i.a;
      end
      ALU_SUB: begin
        add_y   = ~alu_req_i.b;
        add_cin = 1'b1;
      end
      ALU_MAC: begin
        add_x = ALU_W'(prod);
      end
      default: begin
        add_x = alu_req_i.a;
      end
    endcase
  end

  assign alu_res_o = (ALU_W + 1)'(add_x) + (ALU_W + 1)'(add_y) + (ALU_W + 1)'(add_cin);

endmodule

`default_nettype wire

>>> hw/rtl/vdis_div.sv
// Restoring serial divider for the mean gap: total gap over gap count.
// One quotient bit per cycle.
// Depends on vdis_pkg.
`default_nettype none

module vdis_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vdis_pkg::div_req_t div_req_i,
  output vdis_pkg::div_rsp_t div_rsp_o
);
  import vdis_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     dsr_q, dsr_d;

  logic [CNT_W:0]       shifted;
  logic [CNT_W+1:0]     trial;
  logic                 fits;

  // Shift in the next dividend bit and trial subtract
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = ~trial[CNT_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (div_req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(SUM_W - 1);
      rem_d  = '0;
      quo_d  = div_req_i.dividend;
      dsr_d  = div_req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign div_rsp_o.busy = busy_q;
  assign div_rsp_o.done = done_q;
  assign div_rsp_o.quot = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/voltage_dip_and_interval_stats_unit.sv
// Top level of the voltage dip and interval statistics unit.
// Sequencer, statistics state and registers; uses vdis_alu, vdis_div and vdis_pkg.
//
//   Channel | Signals                            | Moves
//   --------+------------------------------------+----------------------------------
//   in      | in_valid_i, in_ready_o, in_req_i   | sample or end-of-window request
//   out     | out_valid_o, out_ready_i, out_res_o| window report
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i   | register write, no handshake
//
// A sample request runs one step of the shared ALU per state: difference, two
// multiply-accumulates, gap, total (the very first sample, which has no gap,
// skips the total). A report request goes straight to the output step with no gaps
// in the window, otherwise it first waits for the serial divider.
// in_ready_o is high only while the sequencer is idle. The report sits in an
// output register, so samples are taken while it waits; a further report waits
// until the previous one is taken. Reset loads the register defaults and clears
// all statistics.
`default_nettype none

module voltage_dip_and_interval_stats_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  vdis_pkg::in_item_t                 in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vdis_pkg::out_item_t                out_res_o,
  input  logic                               cfg_we_i,
  input  logic [vdis_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vdis_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import vdis_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIFF  = 8'b0000_0010,
    ST_MUL_A = 8'b0000_0100,
    ST_MUL_B = 8'b0000_1000,
    ST_GAP   = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [GAP_W-1:0]       GAP_MAX   = '1;
  localparam logic [SUM_W-1:0]       SUM_MAX   = '1;
  localparam logic [CNT_W-1:0]       CNT_MAX   = '1;
  localparam logic [MULB_W-1:0]      W_ONE     = MULB_W'(1) << WEIGHT_W;

  state_e state_q, state_d;

  // Registers
  logic [MARGIN_W-1:0] dip_margin_q, dip_margin_d;
  logic [MARGIN_W-1:0] rearm_margin_q, rearm_margin_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;

  // Statistics state
  logic [AVG_W-1:0]       avg_q, avg_d;
  logic                   dipped_q, dipped_d;
  logic [CNT_W-1:0]       dip_cnt_q, dip_cnt_d;
  logic [SAMPLE_BITS-1:0] win_min_q, win_min_d;
  logic [SAMPLE_BITS-1:0] win_max_q, win_max_d;
  logic [CNT_W-1:0]       win_samples_q, win_samples_d;
  logic [CNT_W-1:0]       gap_cnt_q, gap_cnt_d;
  logic [SUM_W-1:0]       isum_q, isum_d;
  logic [ALU_W-1:0]       last_stamp_q, last_stamp_d;
  logic                   have_stamp_q, have_stamp_d;
  logic [GAP_W-1:0]       min_gap_q, min_gap_d;
  logic [GAP_W-1:0]       max_gap_q, max_gap_d;

  // Working registers of one request
  logic [SAMPLE_BITS-1:0] level_q, level_d;
  logic [STAMP_W-1:0]     stamp_q, stamp_d;
  logic [CMP_W-1:0]       diff_q, diff_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [GAP_W-1:0]       gap_q, gap_d;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  alu_req_t           alu_req;
  logic [ALU_W:0]     alu_res;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [AVG_W-1:0]        scaled;
  logic signed [CMP_W-1:0] dip_thr;
  logic signed [CMP_W-1:0] rearm_thr;
  logic                    dip_hit;
  logic                    rearm_hit;
  logic                    dipped_mid;
  logic [GAP_W-1:0]        mean_gap;

  vdis_alu u_alu (
    .alu_req_i (alu_req),
    .alu_res_o (alu_res)
  );

  vdis_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  // Sample in average format and margin thresholds in the same scale
  assign scaled    = {level_q, {EMA_FRAC_BITS{1'b0}}};
  assign dip_thr   = $signed(CMP_W'($signed(dip_margin_q))) <<< EMA_FRAC_BITS;
  assign rearm_thr = $signed(CMP_W'($signed(rearm_margin_q))) <<< EMA_FRAC_BITS;
  assign dip_hit   = ($signed(diff_q) <= dip_thr) && !dipped_q;
  assign rearm_hit = $signed(diff_q) > rearm_thr;
  assign dipped_mid = dipped_q | dip_hit;

  // Saturate the quotient; no gaps reports zero
  assign mean_gap = (gap_cnt_q == '0)       ? '0 :
                    (|div_rsp.quot[SUM_W-1:GAP_W]) ? GAP_MAX :
                    div_rsp.quot[GAP_W-1:0];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Drive the shared ALU from the sequencer step
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.m  = '0;
    unique case (state_q)
      ST_DIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(scaled);
        alu_req.b  = ALU_W'(avg_q);
      end
      ST_MUL_A: begin
        alu_req.op = ALU_MAC;
        alu_req.a  = ALU_W'(avg_q);
        alu_req.m  = W_ONE - MULB_W'(weight_q);
      end
      ST_MUL_B: begin
        alu_req.op = ALU_MAC;
        alu_req.a  = ALU_W'(scaled);
        alu_req.b  = ALU_W'(prod_q);
        alu_req.m  = MULB_W'(weight_q);
      end
      ST_GAP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(stamp_q);
        alu_req.b  = last_stamp_q;
      end
      ST_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(isum_q);
        alu_req.b  = ALU_W'(gap_q);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_d        = state_q;
    dip_margin_d   = dip_margin_q;
    rearm_margin_d = rearm_margin_q;
    weight_d       = weight_q;
    avg_d          = avg_q;
    dipped_d       = dipped_q;
    dip_cnt_d      = dip_cnt_q;
    win_min_d      = win_min_q;
    win_max_d      = win_max_q;
    win_samples_d  = win_samples_q;
    gap_cnt_d      = gap_cnt_q;
    isum_d         = isum_q;
    last_stamp_d   = last_stamp_q;
    have_stamp_d   = have_stamp_q;
    min_gap_d      = min_gap_q;
    max_gap_d      = max_gap_q;
    level_d        = level_q;
    stamp_d        = stamp_q;
    diff_d         = diff_q;
    prod_d         = prod_q;
    gap_d          = gap_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    div_req.start    = 1'b0;
    div_req.dividend = isum_q;
    div_req.divisor  = gap_cnt_q;

    // Register writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIP_MARGIN:   dip_margin_d   = cfg_wdata_i[MARGIN_W-1:0];
        CFG_REARM_MARGIN: rearm_margin_d = cfg_wdata_i[MARGIN_W-1:0];
        CFG_EMA_WEIGHT:   weight_d       = cfg_wdata_i[WEIGHT_W-1:0];
        default: begin
          weight_d = weight_q;
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.req_type == REQ_SAMPLE) begin
            level_d = SAMPLE_BITS'(in_req_i.sample_level);
            stamp_d = in_req_i.sample_time_ns;
            state_d = ST_DIFF;
          end else if (gap_cnt_q != '0) begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIFF: begin
        diff_d  = alu_res[CMP_W-1:0];
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        // Open or close a dip against the average from before the sample
        prod_d = alu_res[PROD_W-1:0];
        if (dip_hit && dip_cnt_q != CNT_MAX) begin
          dip_cnt_d = dip_cnt_q + 1'b1;
        end
        dipped_d = dipped_mid & ~rearm_hit;
        state_d  = ST_MUL_B;
      end
      ST_MUL_B: begin
        avg_d = alu_res[AVG_W+WEIGHT_W-1:WEIGHT_W];
        if (level_q > win_max_q) begin
          win_max_d = level_q;
        end
        if (level_q < win_min_q) begin
          win_min_d = level_q;
        end
        if (win_samples_q != CNT_MAX) begin
          win_samples_d = win_samples_q + 1'b1;
        end
        state_d = ST_GAP;
      end
      ST_GAP: begin
        // Backward stamps give a zero gap, wide gaps saturate
        if (!alu_res[ALU_W]) begin
          gap_d = '0;
        end else if (|alu_res[ALU_W-1:GAP_W]) begin
          gap_d = GAP_MAX;
        end else begin
          gap_d = alu_res[GAP_W-1:0];
        end
        last_stamp_d = ALU_W'(stamp_q);
        have_stamp_d = 1'b1;
        state_d      = have_stamp_q ? ST_ACC : ST_IDLE;
      end
      ST_ACC: begin
        isum_d = (|alu_res[ALU_W:SUM_W]) ? SUM_MAX : alu_res[SUM_W-1:0];
        if (gap_cnt_q != CNT_MAX) begin
          gap_cnt_d = gap_cnt_q + 1'b1;
        end
        if (gap_q > max_gap_q) begin
          max_gap_d = gap_q;
        end
        if (gap_q != '0 && gap_q < min_gap_q) begin
          min_gap_d = gap_q;
        end
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Load the report once the result register is free, then clear the window
        if (!out_valid_q) begin
          out_d.min_level    = LEVEL_W'(win_min_q);
          out_d.max_level    = LEVEL_W'(win_max_q);
          out_d.mean_level   = LEVEL_W'(avg_q[AVG_W-1:EMA_FRAC_BITS]);
          out_d.dips_seen    = dip_cnt_q;
          out_d.samples_seen = win_samples_q;
          out_d.min_gap_ns   = min_gap_q;
          out_d.max_gap_ns   = max_gap_q;
          out_d.mean_gap_ns  = mean_gap;
          out_valid_d        = 1'b1;
          dip_cnt_d          = '0;
          win_min_d          = LEVEL_MAX;
          win_max_d          = '0;
          win_samples_d      = '0;
          gap_cnt_d          = '0;
          isum_d             = '0;
          min_gap_d          = GAP_MAX;
          max_gap_d          = '0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, register and statistics state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      dip_margin_q   <= DIP_MARGIN_RST;
      rearm_margin_q <= REARM_MARGIN_RST;
      weight_q       <= EMA_WEIGHT_RST;
      avg_q          <= '0;
      dipped_q       <= 1'b0;
      dip_cnt_q      <= '0;
      win_min_q      <= LEVEL_MAX;
      win_max_q      <= '0;
      win_samples_q  <= '0;
      gap_cnt_q      <= '0;
      isum_q         <= '0;
      last_stamp_q   <= '0;
      have_stamp_q   <= 1'b0;
      min_gap_q      <= GAP_MAX;
      max_gap_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      dip_margin_q   <= dip_margin_d;
      rearm_margin_q <= rearm_margin_d;
      weight_q       <= weight_d;
      avg_q          <= avg_d;
      dipped_q       <= dipped_d;
      dip_cnt_q      <= dip_cnt_d;
      win_min_q      <= win_min_d;
      win_max_q      <= win_max_d;
      win_samples_q  <= win_samples_d;
      gap_cnt_q      <= gap_cnt_d;
      isum_q         <= isum_d;
      last_stamp_q   <= last_stamp_d;
      have_stamp_q   <= have_stamp_d;
      min_gap_q      <= min_gap_d;
      max_gap_q      <= max_gap_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    stamp_q <= stamp_d;
    diff_q  <= diff_d;
    prod_q  <= prod_d;
    gap_q   <= gap_d;
    out_q   <= out_d;
  end

  // A recorded minimum gap implies at least one counted gap
  a_min_gap_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_gap_q != GAP_MAX |-> gap_cnt_q != '0)
    else $error("minimum gap recorded without a counted gap");

  // No gap can be counted before the first timestamp
  a_gap_needs_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_stamp_q |-> gap_cnt_q == '0)
    else $error("gap counted before any timestamp");

  // A window with samples has its minimum at or below its maximum
  a_win_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_samples_q != '0 |-> win_min_q <= win_max_q)
    else $error("window minimum above maximum");

  // The divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for voltage_dip_and_interval_stats_unit: random and directed
// sample and report requests, register writes between phases, reports checked per field.
// Depends on vdis_pkg and the unit's RTL only.

module tb_top;
  import vdis_pkg::*;

  localparam int          SETTLE_CYCLES  = 64;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam logic [63:0] GAP_ALL        = (64'd1 << GAP_W) - 64'd1;
  localparam logic [63:0] SUM_ALL        = (64'd1 << SUM_W) - 64'd1;
  localparam longint      EMA_ONE        = longint'(1) << EMA_FRAC_BITS;
  localparam logic [STAMP_W-1:0] STAMP_TOP = '1;

  typedef struct packed {
    logic     drain_first;
    in_item_t req;
  } queued_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  queued_req_t pending_reqs[$];
  out_item_t   expected_reports[$];
  bit          req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  logic [STAMP_W-1:0] gen_stamp = '0;

  // Register copies and statistics state of the predictor
  logic [MARGIN_W-1:0] dip_margin_r   = DIP_MARGIN_RST;
  logic [MARGIN_W-1:0] rearm_margin_r = REARM_MARGIN_RST;
  logic [WEIGHT_W-1:0] ema_weight_r   = EMA_WEIGHT_RST;
  logic [AVG_W-1:0]    ema_avg     = '0;
  logic                dip_open    = 1'b0;
  logic [CNT_W-1:0]    dip_total   = '0;
  logic [LEVEL_W-1:0]  win_min     = '1;
  logic [LEVEL_W-1:0]  win_max     = '0;
  logic [CNT_W-1:0]    win_samples = '0;
  logic [CNT_W-1:0]    gap_cnt     = '0;
  logic [SUM_W-1:0]    gap_sum     = '0;
  logic [STAMP_W-1:0]  prev_stamp  = '0;
  logic                stamp_seen  = 1'b0;
  logic [GAP_W-1:0]    gap_min     = '1;
  logic [GAP_W-1:0]    gap_max     = '0;

  voltage_dip_and_interval_stats_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fold one sample into the moving average, dip tracker and window figures
  function automatic void fold_sample(input logic [LEVEL_W-1:0] level,
                                      input logic [STAMP_W-1:0] stamp);
    logic [63:0] scaled_u;
    longint      scaled;
    longint      dip_thr;
    longint      rearm_thr;
    logic [63:0] blend;
    logic [63:0] gap;
    logic [63:0] total;
    scaled_u  = 64'(level) << EMA_FRAC_BITS;
    scaled    = longint'(scaled_u);
    dip_thr   = longint'(ema_avg) + longint'($signed(dip_margin_r)) * EMA_ONE;
    rearm_thr = longint'(ema_avg) + longint'($signed(rearm_margin_r)) * EMA_ONE;
    if (scaled <= dip_thr && !dip_open) begin
      if (dip_total != '1) dip_total++;
      dip_open = 1'b1;
    end
    if (scaled > rearm_thr) dip_open = 1'b0;

    blend = (64'(ema_avg) * (64'd65536 - 64'(ema_weight_r)) +
             scaled_u * 64'(ema_weight_r)) >> 16;
    ema_avg = blend[AVG_W-1:0];

    if (level > win_max) win_max = level;
    if (level < win_min) win_min = level;
    if (win_samples != '1) win_samples++;

    // The first sample ever has nothing to measure a gap from
    if (stamp_seen) begin
      gap = (stamp >= prev_stamp) ? 64'(stamp) - 64'(prev_stamp) : 64'd0;
      if (gap > GAP_ALL) gap = GAP_ALL;
      total = 64'(gap_sum) + gap;
      gap_sum = (total > SUM_ALL) ? SUM_ALL[SUM_W-1:0] : total[SUM_W-1:0];
      if (gap_cnt != '1) gap_cnt++;
      if (gap > 64'(gap_max)) gap_max = gap[GAP_W-1:0];
      if (gap != 0 && gap < 64'(gap_min)) gap_min = gap[GAP_W-1:0];
    end
    prev_stamp = stamp;
    stamp_seen = 1'b1;
  endfunction

  // Build the window report, then clear the window figures and the dip count
  function automatic out_item_t close_window();
    out_item_t   rpt;
    logic [63:0] mean_gap;
    mean_gap = 64'd0;
    if (gap_cnt != 0) mean_gap = 64'(gap_sum) / 64'(gap_cnt);
    if (mean_gap > GAP_ALL) mean_gap = GAP_ALL;
    rpt.min_level    = win_min;
    rpt.max_level    = win_max;
    rpt.mean_level   = ema_avg[AVG_W-1 -: LEVEL_W];
    rpt.dips_seen    = dip_total;
    rpt.samples_seen = win_samples;
    rpt.min_gap_ns   = gap_min;
    rpt.max_gap_ns   = gap_max;
    rpt.mean_gap_ns  = mean_gap[GAP_W-1:0];
    dip_total   = '0;
    win_min     = '1;
    win_max     = '0;
    win_samples = '0;
    gap_cnt     = '0;
    gap_sum     = '0;
    gap_min     = '1;
    gap_max     = '0;
    return rpt;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] got,
                                      input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
    end
  endfunction

  function automatic in_item_t sample_req(input logic [LEVEL_W-1:0] level,
                                          input logic [STAMP_W-1:0] stamp);
    in_item_t r;
    r.req_type       = REQ_SAMPLE;
    r.sample_level   = level;
    r.sample_time_ns = stamp;
    return r;
  endfunction

  // Level and stamp of a report are don't-care, so fill them at random
  function automatic in_item_t report_req();
    in_item_t    r;
    logic [63:0] wide;
    wide             = {$urandom, $urandom};
    r.req_type       = REQ_REPORT;
    r.sample_level   = LEVEL_W'($urandom_range(4095));
    r.sample_time_ns = wide[STAMP_W-1:0];
    return r;
  endfunction

  function automatic void enqueue(input in_item_t r, input logic drain);
    queued_req_t q;
    q.drain_first = drain;
    q.req         = r;
    pending_reqs.push_back(q);
  endfunction

  // Mostly near the window's base level so dips and rearms happen
  function automatic logic [LEVEL_W-1:0] pick_level(input int base);
    int r;
    int lv;
    r = $urandom_range(99);
    if (r < 70) begin
      lv = base + int'($urandom_range(1200)) - 600;
      if (lv < 0) lv = 0;
      if (lv > 4095) lv = 4095;
    end else if (r < 85) begin
      lv = $urandom_range(4095);
    end else if (r < 92) begin
      lv = 0;
    end else begin
      lv = 4095;
    end
    return lv[LEVEL_W-1:0];
  endfunction

  // Advance near 1 ms, with repeats, tiny steps, backward steps, huge jumps and wild values
  function automatic logic [STAMP_W-1:0] next_stamp();
    int          r;
    logic [63:0] wide;
    r = $urandom_range(99);
    if (r < 78) begin
      gen_stamp = gen_stamp + 900_000 + $urandom_range(200_000);
    end else if (r < 82) begin
      gen_stamp = gen_stamp + $urandom_range(1, 20);
    end else if (r < 85) begin
      gen_stamp = gen_stamp;
    end else if (r < 89) begin
      gen_stamp = gen_stamp - $urandom_range(5_000_000);
    end else if (r < 93) begin
      gen_stamp = gen_stamp + GAP_ALL[STAMP_W-1:0] + $urandom;
    end else if (r < 97) begin
      wide = {$urandom, $urandom};
      gen_stamp = wide[STAMP_W-1:0];
    end else begin
      gen_stamp = STAMP_TOP - $urandom_range(3_000_000);
    end
    return gen_stamp;
  endfunction

  // Windows of random length closed by a report, with some stray requests between
  task automatic queue_random_windows(input int n_items);
    int          queued;
    int          nsamp;
    int          base;
    logic [63:0] wide;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(99) < 8) begin
        wide = {$urandom, $urandom};
        if ($urandom_range(1) == 0) enqueue(report_req(), 1'b0);
        else enqueue(sample_req(LEVEL_W'($urandom_range(4095)), wide[STAMP_W-1:0]), 1'b0);
        queued++;
      end else begin
        nsamp = $urandom_range(9);
        base  = $urandom_range(4095);
        repeat (nsamp) enqueue(sample_req(pick_level(base), next_stamp()), 1'b0);
        enqueue(report_req(), $urandom_range(29) == 0);
        queued += nsamp + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DIP_MARGIN:   dip_margin_r   = value[MARGIN_W-1:0];
      CFG_REARM_MARGIN: rearm_margin_r = value[MARGIN_W-1:0];
      CFG_EMA_WEIGHT:   ema_weight_r   = value[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int dip, input int rearm, input int weight);
    write_reg(CFG_DIP_MARGIN, dip[CFG_W-1:0]);
    write_reg(CFG_REARM_MARGIN, rearm[CFG_W-1:0]);
    write_reg(CFG_EMA_WEIGHT, weight[CFG_W-1:0]);
  endtask

  // Hold until every request is taken and every report is back, then let samples finish
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request driver: present the next queued request once the slot is free
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_reqs.size() != 0 &&
          !(pending_reqs[0].drain_first && expected_reports.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        in_req   <= pending_reqs[0].req;
        in_valid <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Report receiver: stall at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on each accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      req_taken = 1'b1;
      if (in_req.req_type == REQ_SAMPLE) fold_sample(in_req.sample_level, in_req.sample_time_ns);
      else expected_reports.push_back(close_window());
    end
  end

  // Check each accepted report against the oldest prediction
  always @(posedge clk) begin : report_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: report with none pending: %h", $realtime, out_res);
      end else begin
        want = expected_reports.pop_front();
        check_field("min_level", out_res.min_level, want.min_level);
        check_field("max_level", out_res.max_level, want.max_level);
        check_field("mean_level", out_res.mean_level, want.mean_level);
        check_field("dips_seen", out_res.dips_seen, want.dips_seen);
        check_field("samples_seen", out_res.samples_seen, want.samples_seen);
        check_field("min_gap_ns", out_res.min_gap_ns, want.min_gap_ns);
        check_field("max_gap_ns", out_res.max_gap_ns, want.max_gap_ns);
        check_field("mean_gap_ns", out_res.mean_gap_ns, want.mean_gap_ns);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part on reset defaults
    send_idle_pct  = 21;
    recv_stall_pct = 48;
    enqueue(report_req(), 1'b0);                              // empty window
    enqueue(sample_req(12'd0, 63'd0), 1'b0);                  // first sample, no gap
    enqueue(sample_req(12'hFFF, 63'd1_000_000), 1'b0);
    enqueue(sample_req(12'hFFF, 63'd1_000_000), 1'b0);        // zero gap
    enqueue(sample_req(12'd0, 63'd500), 1'b0);                // stamp goes back
    enqueue(report_req(), 1'b0);
    enqueue(report_req(), 1'b0);                              // back to back, no gaps
    enqueue(sample_req(12'd2048, STAMP_TOP), 1'b1);           // gap across reports, saturates
    enqueue(sample_req(12'd1, STAMP_TOP - 1), 1'b0);
    enqueue(sample_req(12'd4094, 63'd0), 1'b0);
    enqueue(sample_req(12'd100, GAP_ALL[STAMP_W-1:0]), 1'b0); // gap just fits 40 bits
    enqueue(sample_req(12'd100, STAMP_W'(2 * GAP_ALL + 1)), 1'b0); // one past, saturates
    enqueue(sample_req(12'd100, STAMP_W'(2 * GAP_ALL + 2)), 1'b0); // smallest positive gap
    enqueue(sample_req(12'h555, STAMP_W'(2 * GAP_ALL + 1_000_001)), 1'b0);
    enqueue(sample_req(12'hAAA, STAMP_W'(2 * GAP_ALL + 2_000_003)), 1'b0);
    enqueue(report_req(), 1'b0);
    enqueue(sample_req(12'd3000, STAMP_W'(2 * GAP_ALL + 3_000_000)), 1'b0);
    gen_stamp = STAMP_W'(2 * GAP_ALL + 3_000_000);
    wait_drained();

    set_regs(4095, -4095, 65535);
    queue_random_windows(130);
    wait_drained();

    send_idle_pct  = 48;
    recv_stall_pct = 21;
    set_regs(-4095, 4095, 0);
    queue_random_windows(130);
    wait_drained();
    set_regs(int'($urandom_range(8190)) - 4095, int'($urandom_range(8190)) - 4095,
             $urandom_range(65535));
    queue_random_windows(130);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(228, 296, 66);
    queue_random_windows(150);
    wait_drained();
    set_regs(int'($urandom_range(8190)) - 4095, int'($urandom_range(8190)) - 4095,
             $urandom_range(65535));
    queue_random_windows(130);
    wait_drained();
    set_regs(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
             $urandom_range(4096));
    queue_random_windows(130);
    wait_drained();

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> voltage_dip_and_interval_stats_unit.f
hw/rtl/vdis_pkg.sv
hw/rtl/vdis_alu.sv
hw/rtl/vdis_div.sv
hw/rtl/voltage_dip_and_interval_stats_unit.sv
test/tb_top.sv
